### rtl/u8u16_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_LEAD  = 2'd1;
   localparam logic [1:0] ERR_CONT  = 2'd2;
   localparam logic [1:0] ERR_RANGE = 2'd3;

   localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
   localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
   localparam logic [31:0] MAX_CODE_POINT = 32'h0010FFFF;
   localparam logic [10:0] PLANE_ONE_HIGH = 11'h040;

   // one decoded request waiting for the output side
   typedef struct packed {
      logic [15:0] unit_hi;
      logic [15:0] unit_lo;
      logic [2:0]  size;
      logic [1:0]  kind;
      logic [2:0]  pos;
      logic        pair;
   } job_type;

endpackage
`default_nettype wire

### rtl/u8u16_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_req_if
// Byte request channel of the decoder.
// ----------------------------------------------------------------------------
interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

### rtl/u8u16_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_rsp_if
// Code unit response channel of the decoder.
// ----------------------------------------------------------------------------
interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic [2:0]  char_size;
   logic [1:0]  error_kind;
   logic [2:0]  error_position;
   logic        last_of_run;

   modport source (output valid, output code_unit, output char_size, output error_kind,
                   output error_position, output last_of_run, input ready);
   modport sink (input valid, input code_unit, input char_size, input error_kind,
                 input error_position, input last_of_run, output ready);
endinterface
`default_nettype wire

### rtl/utf8_to_utf16_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// UTF-8 byte stream in, UTF-16 code units with size and error tags out.
// ----------------------------------------------------------------------------
// One byte request is taken per clock while the job queue has room; a byte
// that completes a character or hits an error turns into a job in the same
// cycle, and responses leave the output register at one per clock while
// the receiver is ready. A character above the basic plane takes two
// responses (high then low surrogate). A job passes from its queue slot
// into the output register before it is shown. QUEUE_DEPTH sets how many
// decoded jobs may wait for the output side.
module utf8_to_utf16_decoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic   clock,
   input  wire logic   reset,
   u8u16_req_if.sink   req_if,
   u8u16_rsp_if.source rsp_if
);

   u8u16_pkg::job_type push_job;
   u8u16_pkg::job_type pop_job;
   logic               push;
   logic               pop;
   logic               q_full;
   logic               q_empty;

   u8u16_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_full   (q_full),
      .push_job (push_job),
      .push     (push)
   );

   u8u16_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   u8u16_back u_back (
      .clock   (clock),
      .reset   (reset),
      .pop_job (pop_job),
      .empty   (q_empty),
      .pop     (pop),
      .rsp_if  (rsp_if)
   );

endmodule
`default_nettype wire

### rtl/u8u16_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_front
// Takes bytes, tracks the open sequence and turns each finished character
// or error into a job for the output side.
// ----------------------------------------------------------------------------
module u8u16_front (
   input  wire logic         clock,
   input  wire logic         reset,
   u8u16_req_if.sink         req_if,
   input  wire logic         q_full,
   output u8u16_pkg::job_type push_job,
   output logic              push
);

   logic [31:0] acc_ff, acc_in;
   logic [2:0]  rem_ff, rem_in;
   logic [2:0]  len_ff, len_in;

   logic [7:0]  b;
   logic        take;
   logic [2:0]  lead_len;
   logic [7:0]  lead_mask;
   logic [2:0]  pos;
   logic [31:0] val;
   logic [10:0] hi_off;
   logic        has_job;
   u8u16_pkg::job_type job;

   assign req_if.ready = !q_full;
   assign b    = req_if.data_byte;
   assign take = req_if.valid && !q_full;

   always_comb begin
      if (b < 8'hE0) begin
         lead_len = 3'd2; lead_mask = 8'h1F;
      end else if (b < 8'hF0) begin
         lead_len = 3'd3; lead_mask = 8'h0F;
      end else if (b < 8'hF8) begin
         lead_len = 3'd4; lead_mask = 8'h07;
      end else if (b < 8'hFC) begin
         lead_len = 3'd5; lead_mask = 8'h03;
      end else begin
         lead_len = 3'd6; lead_mask = 8'h01;
      end
   end

   // payload bits only: the length offset never enters the value
   assign val    = {acc_ff[25:0], b[5:0]};
   assign pos    = 3'(len_ff - rem_ff + 3'd1);
   assign hi_off = 11'(val[20:10] - u8u16_pkg::PLANE_ONE_HIGH);

   always_comb begin
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      len_in  = len_ff;
      has_job = 1'b0;
      job     = '0;
      if (rem_ff == 3'd0) begin
         if (b < 8'h80) begin
            has_job     = 1'b1;
            job.unit_hi = {8'h00, b};
            job.size    = 3'd1;
         end else if (b < 8'hC0 || b >= 8'hFE) begin
            has_job  = 1'b1;
            job.kind = u8u16_pkg::ERR_LEAD;
            job.pos  = 3'd1;
         end else begin
            acc_in = {24'h000000, b & lead_mask};
            len_in = lead_len;
            rem_in = 3'(lead_len - 3'd1);
         end
      end else if (b[7:6] != 2'b10) begin
         has_job  = 1'b1;
         job.kind = u8u16_pkg::ERR_CONT;
         job.pos  = pos;
         rem_in   = 3'd0;
         len_in   = 3'd0;
      end else begin
         rem_in = 3'(rem_ff - 3'd1);
         acc_in = val;
         if (rem_ff == 3'd1) begin
            has_job = 1'b1;
            len_in  = 3'd0;
            if (val[31:16] == 16'h0000) begin
               job.unit_hi = val[15:0];
               job.size    = len_ff;
            end else if (val > u8u16_pkg::MAX_CODE_POINT) begin
               job.kind = u8u16_pkg::ERR_RANGE;
               job.pos  = len_ff;
            end else begin
               job.unit_hi = u8u16_pkg::SURR_HIGH_BASE | {6'h00, hi_off[9:0]};
               job.unit_lo = u8u16_pkg::SURR_LOW_BASE | {6'h00, val[9:0]};
               job.size    = len_ff;
               job.pair    = 1'b1;
            end
         end
      end
   end

   assign push     = take && has_job;
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
         len_ff <= 3'd0;
      end else if (take) begin
         rem_ff <= rem_in;
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         acc_ff <= acc_in;
      end
   end

endmodule
`default_nettype wire

### rtl/u8u16_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_queue
// Short show-ahead queue of decoded jobs between the two halves.
// ----------------------------------------------------------------------------
module u8u16_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire u8u16_pkg::job_type push_job,
   output logic                    full,
   input  wire logic               pop,
   output u8u16_pkg::job_type      pop_job,
   output logic                    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   u8u16_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("job popped from an empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

### rtl/u8u16_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_back
// Output register: plays out one job as one response, or two for a
// surrogate pair.
// ----------------------------------------------------------------------------
module u8u16_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire u8u16_pkg::job_type pop_job,
   input  wire logic               empty,
   output logic                    pop,
   u8u16_rsp_if.source             rsp_if
);

   logic        valid_ff, valid_in;
   logic        low_pend_ff, low_pend_in;
   logic [15:0] low_unit_ff, low_unit_in;
   logic [15:0] unit_ff, unit_in;
   logic [2:0]  size_ff, size_in;
   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  pos_ff, pos_in;
   logic        last_ff, last_in;

   logic        take_out;
   logic        load_ok;

   assign take_out = valid_ff && rsp_if.ready;
   assign load_ok  = !valid_ff || (take_out && !low_pend_ff);
   assign pop      = load_ok && !empty;

   always_comb begin
      valid_in    = valid_ff;
      low_pend_in = low_pend_ff;
      low_unit_in = low_unit_ff;
      unit_in     = unit_ff;
      size_in     = size_ff;
      kind_in     = kind_ff;
      pos_in      = pos_ff;
      last_in     = last_ff;
      if (take_out && low_pend_ff) begin
         unit_in     = low_unit_ff;
         size_in     = 3'd0;
         kind_in     = u8u16_pkg::ERR_NONE;
         pos_in      = 3'd0;
         last_in     = 1'b1;
         low_pend_in = 1'b0;
      end else if (pop) begin
         valid_in    = 1'b1;
         unit_in     = pop_job.unit_hi;
         size_in     = pop_job.size;
         kind_in     = pop_job.kind;
         pos_in      = pop_job.pos;
         last_in     = !pop_job.pair;
         low_pend_in = pop_job.pair;
         low_unit_in = pop_job.unit_lo;
      end else if (take_out) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         low_pend_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         low_pend_ff <= low_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      low_unit_ff <= low_unit_in;
      unit_ff     <= unit_in;
      size_ff     <= size_in;
      kind_ff     <= kind_in;
      pos_ff      <= pos_in;
      last_ff     <= last_in;
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.code_unit      = unit_ff;
   assign rsp_if.char_size      = size_ff;
   assign rsp_if.error_kind     = kind_ff;
   assign rsp_if.error_position = pos_ff;
   assign rsp_if.last_of_run    = last_ff;

`ifndef SYNTHESIS
   a_low_behind_high: assert property (@(posedge clock) disable iff (reset)
      low_pend_ff |-> (valid_ff && !last_ff))
      else $error("pending low surrogate without a high surrogate on show");
   a_low_follows: assert property (@(posedge clock) disable iff (reset)
      (take_out && low_pend_ff) |=> (valid_ff && last_ff && size_ff == 3'd0))
      else $error("low surrogate did not follow its high surrogate");
`endif

endmodule
`default_nettype wire
